@@ src/dda_pkg.sv @@
// dda_pkg: shared types and constants for the decimal digit array adder
// no dependencies; imported by dda_digit_add and decimal_digit_array_adder
package dda_pkg;

  localparam int DIGIT_W = 4;
  localparam int CARRY_W = 2;

  // action codes of an input item
  localparam logic [1:0] ACT_LOAD_A  = 2'd0;
  localparam logic [1:0] ACT_LOAD_B  = 2'd1;
  localparam logic [1:0] ACT_COMPUTE = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ADD_RD,
    ST_ADD_WR,
    ST_CARRY,
    ST_SCAN_RD,
    ST_SCAN_CHK,
    ST_EMIT_RD,
    ST_EMIT_OUT
  } state_t;

endpackage

@@ src/dda_digit_add.sv @@
// dda_digit_add: one decimal column, two digits plus carry in
// depends on dda_pkg
module dda_digit_add (
  input  logic [dda_pkg::DIGIT_W-1:0] a,
  input  logic [dda_pkg::DIGIT_W-1:0] b,
  input  logic [dda_pkg::CARRY_W-1:0] carry_in,
  output logic [dda_pkg::DIGIT_W-1:0] sum,
  output logic [dda_pkg::CARRY_W-1:0] carry_out
);
  import dda_pkg::*;

  logic [5:0] total;

  assign total = 6'(a) + 6'(b) + 6'(carry_in);

  // total is at most 33, so three compares settle the decimal split
  always_comb begin
    priority if (total >= 6'd30) begin
      sum       = DIGIT_W'(total - 6'd30);
      carry_out = 2'd3;
    end else if (total >= 6'd20) begin
      sum       = DIGIT_W'(total - 6'd20);
      carry_out = 2'd2;
    end else if (total >= 6'd10) begin
      sum       = DIGIT_W'(total - 6'd10);
      carry_out = 2'd1;
    end else begin
      sum       = DIGIT_W'(total);
      carry_out = 2'd0;
    end
  end

endmodule

@@ src/decimal_digit_array_adder.sv @@
// decimal_digit_array_adder: top level, digit stores, sequencer and output register
// depends on dda_pkg and dda_digit_add
//
// usage
//   input channel (in_valid / in_stall): action and digit. action 0 loads a digit
//   into the first operand store, 1 into the second, most significant first.
//   action 2 adds the two operands and emits the sum; action 3 is ignored.
//   output channel (out_valid / out_stall): one item per sum digit, most
//   significant first, leading zeros dropped; last marks the least significant
//   digit and overflow reports a load into a full store since the last compute.
//   a zero sum or empty operands give a single item, digit 0 with last set.
// sequence
//   a load is written from the idle state. a compute of len = max(count) digits
//   runs each column through the shared digit adder (a memory read step, then an
//   add and write step), then the carry step; each leading zero skipped takes a
//   read and a check step, and each emitted digit after the first a read and an
//   output step, all bound by the single read port of the sum store. in_stall is
//   high for the whole compute.
// reset and stall
//   rst clears both counts, the overflow flag, the sequencer and out_valid; the
//   digit stores hold garbage until written. while out_stall is high the output
//   register holds its item and the sequencer waits before the next digit.
module decimal_digit_array_adder #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  action,
  input  logic [dda_pkg::DIGIT_W-1:0] digit,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [dda_pkg::DIGIT_W-1:0] sum_digit,
  output logic                        last,
  output logic                        overflow
);
  import dda_pkg::*;

  localparam int CNT_W   = $clog2(MAX_DIGITS + 1);
  localparam int LEN_W   = $clog2(MAX_DIGITS + 2);
  localparam int ADDR_W  = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
  localparam int SADDR_W = $clog2(MAX_DIGITS + 1);

  // operand and sum stores
  logic [DIGIT_W-1:0] first_digits  [MAX_DIGITS];
  logic [DIGIT_W-1:0] second_digits [MAX_DIGITS];
  logic [DIGIT_W-1:0] sum_store     [MAX_DIGITS+1];

  state_t             state, state_next;
  logic [CNT_W-1:0]   first_count, first_count_next;
  logic [CNT_W-1:0]   second_count, second_count_next;
  logic               load_overflow, load_overflow_next;
  logic [CNT_W-1:0]   col, col_next;
  logic [LEN_W-1:0]   len, len_next;
  logic [CARRY_W-1:0] carry, carry_next;
  logic [SADDR_W-1:0] ptr, ptr_next;

  // memory read data
  logic [DIGIT_W-1:0] a_rd, b_rd, s_rd;
  logic               a_ok, b_ok;

  // memory controls
  logic               a_we, b_we, op_re, sum_we, sum_re;
  logic [SADDR_W-1:0] sum_waddr;
  logic [DIGIT_W-1:0] sum_wdata;
  logic [ADDR_W-1:0]  a_raddr, b_raddr;

  logic               out_load, out_last;

  // shared digit adder
  logic [DIGIT_W-1:0] a_val, b_val, col_sum;
  logic [CARRY_W-1:0] col_carry;

  assign a_val = a_ok ? a_rd : '0;
  assign b_val = b_ok ? b_rd : '0;

  dda_digit_add u_add (
    .a         (a_val),
    .b         (b_val),
    .carry_in  (carry),
    .sum       (col_sum),
    .carry_out (col_carry)
  );

  // operands are right aligned: column col reads count-1-col
  assign a_raddr  = ADDR_W'(first_count - CNT_W'(1) - col);
  assign b_raddr  = ADDR_W'(second_count - CNT_W'(1) - col);

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    state_next         = state;
    first_count_next   = first_count;
    second_count_next  = second_count;
    load_overflow_next = load_overflow;
    col_next           = col;
    len_next           = len;
    carry_next         = carry;
    ptr_next           = ptr;
    a_we               = 1'b0;
    b_we               = 1'b0;
    op_re              = 1'b0;
    sum_we             = 1'b0;
    sum_re             = 1'b0;
    sum_waddr          = SADDR_W'(col);
    sum_wdata          = col_sum;
    out_load           = 1'b0;
    out_last           = 1'b0;

    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (action)
            ACT_LOAD_A: begin
              if (first_count < CNT_W'(MAX_DIGITS)) begin
                a_we             = 1'b1;
                first_count_next = first_count + CNT_W'(1);
              end else begin
                load_overflow_next = 1'b1;
              end
            end
            ACT_LOAD_B: begin
              if (second_count < CNT_W'(MAX_DIGITS)) begin
                b_we              = 1'b1;
                second_count_next = second_count + CNT_W'(1);
              end else begin
                load_overflow_next = 1'b1;
              end
            end
            ACT_COMPUTE: begin
              col_next   = '0;
              carry_next = '0;
              len_next   = (first_count > second_count) ? LEN_W'(first_count)
                                                        : LEN_W'(second_count);
              state_next = ST_ADD_RD;
            end
            default: begin
            end
          endcase
        end
      end
      ST_ADD_RD: begin
        if (LEN_W'(col) == len) begin
          state_next = ST_CARRY;
        end else begin
          op_re      = 1'b1;
          state_next = ST_ADD_WR;
        end
      end
      ST_ADD_WR: begin
        sum_we     = 1'b1;
        carry_next = col_carry;
        col_next   = col + CNT_W'(1);
        state_next = ST_ADD_RD;
      end
      ST_CARRY: begin
        // final carry becomes a leading digit; empty operands store a zero
        if (carry != '0) begin
          sum_we    = 1'b1;
          sum_waddr = SADDR_W'(len);
          sum_wdata = DIGIT_W'(carry);
          len_next  = len + LEN_W'(1);
          ptr_next  = SADDR_W'(len);
        end else if (len == '0) begin
          sum_we    = 1'b1;
          sum_waddr = '0;
          sum_wdata = '0;
          ptr_next  = '0;
        end else begin
          ptr_next  = SADDR_W'(len - LEN_W'(1));
        end
        state_next = ST_SCAN_RD;
      end
      ST_SCAN_RD: begin
        sum_re     = 1'b1;
        state_next = ST_SCAN_CHK;
      end
      ST_SCAN_CHK: begin
        // skip leading zeros; the digit at ptr is already read for emit
        if (s_rd == '0 && ptr != '0) begin
          ptr_next   = ptr - SADDR_W'(1);
          state_next = ST_SCAN_RD;
        end else begin
          state_next = ST_EMIT_OUT;
        end
      end
      ST_EMIT_RD: begin
        sum_re     = 1'b1;
        state_next = ST_EMIT_OUT;
      end
      ST_EMIT_OUT: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          out_last = (ptr == '0);
          if (ptr == '0) begin
            first_count_next   = '0;
            second_count_next  = '0;
            load_overflow_next = 1'b0;
            state_next         = ST_IDLE;
          end else begin
            ptr_next   = ptr - SADDR_W'(1);
            state_next = ST_EMIT_RD;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      first_count   <= '0;
      second_count  <= '0;
      load_overflow <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      state         <= state_next;
      first_count   <= first_count_next;
      second_count  <= second_count_next;
      load_overflow <= load_overflow_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    col   <= col_next;
    len   <= len_next;
    carry <= carry_next;
    ptr   <= ptr_next;
    if (out_load) begin
      sum_digit <= s_rd;
      last      <= out_last;
      overflow  <= load_overflow;
    end
  end

  // operand stores
  always_ff @(posedge clk) begin
    if (a_we) begin
      first_digits[ADDR_W'(first_count)] <= digit;
    end
    if (b_we) begin
      second_digits[ADDR_W'(second_count)] <= digit;
    end
    if (op_re) begin
      a_rd <= first_digits[a_raddr];
      b_rd <= second_digits[b_raddr];
      a_ok <= (col < first_count);
      b_ok <= (col < second_count);
    end
  end

  // sum store
  always_ff @(posedge clk) begin
    if (sum_we) begin
      sum_store[sum_waddr] <= sum_wdata;
    end
    if (sum_re) begin
      s_rd <= sum_store[ptr];
    end
  end

  // counts never pass the store size
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    first_count <= CNT_W'(MAX_DIGITS) && second_count <= CNT_W'(MAX_DIGITS))
    else $error("digit count beyond store size");

  // emitting the least significant digit ends the compute and clears the counts
  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    out_load && out_last |=> state == ST_IDLE && first_count == '0 &&
                             second_count == '0 && !load_overflow)
    else $error("compute did not finish after last digit");

  // every emitted sum digit is decimal
  a_digit_decimal: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sum_digit <= DIGIT_W'(9))
    else $error("sum digit above nine");

  // no new input while the sequencer is busy
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != ST_IDLE |-> in_stall)
    else $error("input taken during compute");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// tb: self-checking bench for decimal_digit_array_adder, a sum model in a small class
// depends on dda_pkg and decimal_digit_array_adder
module tb;
  import dda_pkg::*;

  localparam int MAX_DIGITS   = 32;
  localparam int RANDOM_ITEMS = 260;
  localparam int HOLD_CYCLES  = 300;     // one long receiver hold-off
  localparam int TAIL_CYCLES  = 200;     // quiet time after the last sum digit
  localparam int CYCLE_LIMIT  = 1500000;

  // action 3 has no name in the package; the block must ignore it
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  // one expected output item
  typedef struct packed {
    logic [DIGIT_W-1:0] value;
    logic               last;
    logic               ovf;
  } sum_entry_t;

  logic               clk;
  logic               rst       = 1'b1;
  logic               in_valid  = 1'b0;
  logic               in_stall;
  logic [1:0]         action    = ACT_LOAD_A;
  logic [DIGIT_W-1:0] digit     = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DIGIT_W-1:0] sum_digit;
  logic               last;
  logic               overflow;

  int  cycle_count   = 0;
  int  counted_items = 0;       // loads and computes handed to the block
  bit  send_burst    = 1'b0;    // sender runs without idle cycles while set
  bit  hold_req      = 1'b0;    // asks the receiver for its long hold-off

  // keeps its own copy of the digit stores and predicts every sum digit
  class digit_sum_board;
    logic [DIGIT_W-1:0] first_store[MAX_DIGITS];
    logic [DIGIT_W-1:0] second_store[MAX_DIGITS];
    int                 first_len, second_len;
    bit                 load_lost;
    sum_entry_t         expected_digits[$];
    int                 errors, loads, sums, ignored, overflow_sums, digits_seen, longest;

    function new();
      first_len     = 0;
      second_len    = 0;
      load_lost     = 1'b0;
      errors        = 0;
      loads         = 0;
      sums          = 0;
      ignored       = 0;
      overflow_sums = 0;
      digits_seen   = 0;
      longest       = 0;
    endfunction

    function int pending();
      return expected_digits.size();
    endfunction

    task flag_mismatch(string what);
      errors++;
      $display("[%0t] mismatch: %s", $time, what);
    endtask

    // an item the block has just accepted
    function void note_item(logic [1:0] act, logic [DIGIT_W-1:0] dig);
      logic [DIGIT_W-1:0] column[MAX_DIGITS+1];
      sum_entry_t entry;
      int width, top, carry, total, a, b;
      if (act == ACT_LOAD_A) begin
        loads++;
        if (first_len < MAX_DIGITS) begin
          first_store[first_len] = dig;
          first_len++;
        end else begin
          load_lost = 1'b1;
        end
      end else if (act == ACT_LOAD_B) begin
        loads++;
        if (second_len < MAX_DIGITS) begin
          second_store[second_len] = dig;
          second_len++;
        end else begin
          load_lost = 1'b1;
        end
      end else if (act == ACT_COMPUTE) begin
        sums++;
        if (load_lost) overflow_sums++;
        // right-aligned column add, least significant column first
        width = (first_len > second_len) ? first_len : second_len;
        carry = 0;
        for (int i = 0; i < width; i++) begin
          a = (i < first_len) ? int'(first_store[first_len-1-i]) : 0;
          b = (i < second_len) ? int'(second_store[second_len-1-i]) : 0;
          total = a + b + carry;
          column[i] = DIGIT_W'(total % 10);
          carry = total / 10;
        end
        // digits above nine can push the carry up to three
        if (carry > 0) begin
          column[width] = DIGIT_W'(carry);
          width++;
        end
        if (width == 0) begin
          entry = '{value: '0, last: 1'b1, ovf: load_lost};
          expected_digits.insert(expected_digits.size(), entry);
          top = 0;
        end else begin
          top = width - 1;
          while (top > 0 && column[top] == '0) top--;
          for (int k = top; k >= 0; k--) begin
            entry = '{value: column[k], last: (k == 0), ovf: load_lost};
            expected_digits.insert(expected_digits.size(), entry);
          end
        end
        if (top + 1 > longest) longest = top + 1;
        first_len  = 0;
        second_len = 0;
        load_lost  = 1'b0;
      end else begin
        ignored++;
      end
    endfunction

    // a sum digit the block has just handed over
    task check_digit(logic [DIGIT_W-1:0] value, logic lst, logic ovf);
      sum_entry_t want;
      digits_seen++;
      if (expected_digits.size() == 0) begin
        flag_mismatch($sformatf("sum digit %0d last %0b with nothing expected", value, lst));
        return;
      end
      want = expected_digits.pop_front();
      if (value !== want.value)
        flag_mismatch($sformatf("sum_digit got %0d want %0d", value, want.value));
      if (lst !== want.last)
        flag_mismatch($sformatf("last got %0b want %0b", lst, want.last));
      if (ovf !== want.ovf)
        flag_mismatch($sformatf("overflow got %0b want %0b", ovf, want.ovf));
    endtask
  endclass

  digit_sum_board sb;

  decimal_digit_array_adder #(
    .MAX_DIGITS(MAX_DIGITS)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .action   (action),
    .digit    (digit),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .sum_digit(sum_digit),
    .last     (last),
    .overflow (overflow)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) cycle_count <= cycle_count + 1;

  // watchdog: a hung handshake ends the run here
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("timeout after %0d cycles, %0d sum digits still expected",
             cycle_count, sb.pending());
    $display("FAIL");
    $finish;
  end

  // idle cycles before an item, none at all during a burst stretch
  function automatic int pick_wait(bit burst);
    if (burst) return 0;
    return $urandom_range(0, 16);
  endfunction

  // operand length: mostly short, sometimes long, now and then past capacity
  function automatic int pick_len();
    int roll;
    roll = $urandom_range(0, 29);
    if (roll == 0) return $urandom_range(MAX_DIGITS + 1, MAX_DIGITS + 3);
    if (roll < 5) return $urandom_range(7, MAX_DIGITS);
    return $urandom_range(0, 6);
  endfunction

  // digit by shape: 0 any decimal, 1 all nines, 2 mostly zeros; sometimes above nine
  function automatic logic [DIGIT_W-1:0] pick_digit(int shape);
    if ($urandom_range(0, 7) == 0) return DIGIT_W'($urandom_range(10, 15));
    case (shape)
      1: return DIGIT_W'(9);
      2: return ($urandom_range(0, 3) == 0) ? DIGIT_W'($urandom_range(0, 9)) : '0;
      default: return DIGIT_W'($urandom_range(0, 9));
    endcase
  endfunction

  // offer one item and hold it until the block takes it; valid stays high on exit
  // so a back-to-back item never drops it within one time step
  task automatic send_item(input logic [1:0] act, input logic [DIGIT_W-1:0] dig);
    int idle;
    if ($urandom_range(0, 29) == 0) send_burst = !send_burst;
    idle = pick_wait(send_burst);
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    action   <= act;
    digit    <= dig;
    do @(posedge clk); while (in_stall);
    sb.note_item(act, dig);
    if (act != ACT_UNUSED) counted_items++;
  endtask

  // two operands with their loads interleaved at random, then the compute item
  task automatic send_operands(input int len_a, input int len_b, input int shape);
    int left_a, left_b;
    logic [DIGIT_W-1:0] d;
    left_a = len_a;
    left_b = len_b;
    while (left_a + left_b > 0) begin
      // stray unused action now and then, should leave the stores alone
      if ($urandom_range(0, 19) == 0) send_item(ACT_UNUSED, DIGIT_W'($urandom_range(0, 15)));
      d = pick_digit(shape);
      if ($urandom_range(1, left_a + left_b) <= left_a) begin
        send_item(ACT_LOAD_A, d);
        left_a--;
      end else begin
        send_item(ACT_LOAD_B, d);
        left_b--;
      end
    end
    // digit field is don't-care on compute, so drive anything
    send_item(ACT_COMPUTE, DIGIT_W'($urandom_range(0, 15)));
  endtask

  // sender pause until every predicted sum digit has come out
  task automatic wait_for_sums();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // receiver: random stall before each sum digit, one long hold-off on request
  initial begin : sum_sink
    int idle;
    bit burst, held;
    burst = 1'b0;
    held  = 1'b0;
    wait (!rst);
    forever begin
      if ($urandom_range(0, 29) == 0) burst = !burst;
      idle = (hold_req && !held) ? HOLD_CYCLES : pick_wait(burst);
      held = held | hold_req;
      @(negedge clk);
      if (idle > 0) begin
        out_stall <= 1'b1;
        repeat (idle) @(negedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_digit(sum_digit, last, overflow);
    end
  end

  initial begin : stimulus
    int base;
    int len_a, len_b;
    sb = new();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty operands give a lone zero
    send_item(ACT_COMPUTE, 4'd0);
    // 99 + 1, carry ripples through and is appended once, operands differ in length
    send_item(ACT_LOAD_A, 4'd9);
    send_item(ACT_LOAD_A, 4'd9);
    send_item(ACT_LOAD_B, 4'd1);
    send_item(ACT_COMPUTE, 4'd15);
    // zero sum with leading zeros collapses to a single zero
    send_item(ACT_LOAD_A, 4'd0);
    send_item(ACT_LOAD_A, 4'd0);
    send_item(ACT_LOAD_A, 4'd0);
    send_item(ACT_LOAD_B, 4'd0);
    send_item(ACT_COMPUTE, 4'd0);
    // 15 + 15: digits above nine, carry of three
    send_item(ACT_LOAD_A, 4'd15);
    send_item(ACT_LOAD_B, 4'd15);
    send_item(ACT_COMPUTE, 4'd5);
    // unused action with every digit bit set
    send_item(ACT_UNUSED, 4'd15);
    // only the second operand loaded
    send_item(ACT_LOAD_B, 4'd7);
    send_item(ACT_LOAD_B, 4'd5);
    send_item(ACT_COMPUTE, 4'd10);
    wait_for_sums();

    // store full: first operand past capacity, all nines for the longest sum
    send_operands(MAX_DIGITS + 2, MAX_DIGITS, 1);

    base = counted_items;
    while (counted_items - base < RANDOM_ITEMS) begin
      if (!hold_req && counted_items - base >= 120) begin
        // receiver holds off while two long sums are sent back to back, the second stalled behind the first
        hold_req = 1'b1;
        send_operands(12, 9, 0);
        send_operands(6, 14, 1);
        wait_for_sums();
      end else begin
        len_a = pick_len();
        len_b = pick_len();
        send_operands(len_a, len_b, $urandom_range(0, 2));
      end
    end

    wait_for_sums();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.pending() != 0)
      sb.flag_mismatch($sformatf("%0d sum digits never came out", sb.pending()));

    $display("run covered %0d digit loads, %0d sums (%0d with store overflow), %0d ignored items",
             sb.loads, sb.sums, sb.overflow_sums, sb.ignored);
    $display("checked %0d sum digits, longest sum %0d digits, %0d mismatches",
             sb.digits_seen, sb.longest, sb.errors);
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
src/dda_pkg.sv
src/dda_digit_add.sv
src/decimal_digit_array_adder.sv
tb/sv/tb.sv
